// ----- rtl/core/isotp_rx_pkg.sv -----
`default_nettype none

package isotp_rx_pkg;

	localparam int MAX_MESSAGE_BYTES = 4095;

	localparam int ID_W  = 29;
	localparam int LEN_W = 12;
	localparam int TMO_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_FC   = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_BAD_ID   = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_NO_SPACE = 3'd4;
	localparam logic [2:0] ST_BAD_TYPE = 3'd5;
	localparam logic [2:0] ST_SEQUENCE = 3'd6;

	// PCI frame types (upper nibble of byte 0)
	localparam logic [3:0] PCI_SF = 4'h0;
	localparam logic [3:0] PCI_FF = 4'h1;
	localparam logic [3:0] PCI_CF = 4'h2;

	localparam int SF_MAX_LEN    = 7;
	localparam int FF_MIN_LEN    = 8;
	localparam int FF_DATA_BYTES = 6;
	localparam int CF_DATA_BYTES = 7;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_RX_MASK  = 3'd0;
	localparam logic [2:0] REG_TX_ID    = 3'd1;
	localparam logic [2:0] REG_CAPACITY = 3'd2;
	localparam logic [2:0] REG_BLK_SIZE = 3'd3;
	localparam logic [2:0] REG_ST_MIN   = 3'd4;
	localparam logic [2:0] REG_TIMEOUT  = 3'd5;

	localparam logic [ID_W-1:0]  RST_RX_MASK  = '0;
	localparam logic [ID_W-1:0]  RST_TX_ID    = '0;
	localparam logic [LEN_W-1:0] RST_CAPACITY = 12'd4095;
	localparam logic [3:0]       RST_BLK_SIZE = 4'd8;
	localparam logic [7:0]       RST_ST_MIN   = 8'd10;
	localparam logic [TMO_W-1:0] RST_TIMEOUT  = 16'd1000;

	typedef struct packed {
		logic [ID_W-1:0]  rx_mask;
		logic [ID_W-1:0]  tx_id;
		logic [LEN_W-1:0] capacity;
		logic [3:0]       blk_size;
		logic [7:0]       st_min;
		logic [TMO_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] frame_id;
		logic [7:0]      byte0;
		logic [7:0]      byte1;
		logic [7:0]      byte2;
		logic [7:0]      byte3;
		logic [7:0]      byte4;
		logic [7:0]      byte5;
		logic [7:0]      byte6;
		logic [7:0]      byte7;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] byte_offset;
		logic [ID_W-1:0]  fc_id;
		logic [3:0]       fc_block_size;
		logic [7:0]       fc_separation;
		logic [2:0]       status;
		logic [LEN_W-1:0] message_length;
		logic             last;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic load_byte;
		logic load_tail;
		logic last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic work;       // a result still to go
		logic bytes_left; // next result is a payload byte
		logic closing;    // next result is the last one
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/isotp_rx_if.sv -----
`default_nettype none

interface isotp_rx_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [28:0] frame_id;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;

	modport source (
		output valid, req_type, frame_id, byte0, byte1, byte2, byte3,
		byte4, byte5, byte6, byte7,
		input  ready
	);
	modport sink (
		input  valid, req_type, frame_id, byte0, byte1, byte2, byte3,
		byte4, byte5, byte6, byte7,
		output ready
	);
endinterface

interface isotp_rx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [11:0] byte_offset;
	logic [28:0] fc_id;
	logic [3:0]  fc_block_size;
	logic [7:0]  fc_separation;
	logic [2:0]  status;
	logic [11:0] message_length;
	logic        last;

	modport source (
		output valid, kind, payload_byte, byte_offset, fc_id, fc_block_size,
		fc_separation, status, message_length, last,
		input  ready
	);
	modport sink (
		input  valid, kind, payload_byte, byte_offset, fc_id, fc_block_size,
		fc_separation, status, message_length, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/isotp_rx_cfg.sv -----
`default_nettype none

module isotp_rx_cfg (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [isotp_rx_pkg::ADDR_W-1:0]       paddr,
	input  wire  [isotp_rx_pkg::DATA_W-1:0]       pwdata,
	output logic [isotp_rx_pkg::DATA_W-1:0]       prdata,
	output isotp_rx_pkg::cfg_t                    cfg
);
	import isotp_rx_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_mask  <= RST_RX_MASK;
			cfg_q.tx_id    <= RST_TX_ID;
			cfg_q.capacity <= RST_CAPACITY;
			cfg_q.blk_size <= RST_BLK_SIZE;
			cfg_q.st_min   <= RST_ST_MIN;
			cfg_q.timeout  <= RST_TIMEOUT;
		end else if (wr) begin
			case (idx)
				REG_RX_MASK:  cfg_q.rx_mask  <= pwdata[ID_W-1:0];
				REG_TX_ID:    cfg_q.tx_id    <= pwdata[ID_W-1:0];
				REG_CAPACITY: cfg_q.capacity <= pwdata[LEN_W-1:0];
				REG_BLK_SIZE: cfg_q.blk_size <= pwdata[3:0];
				REG_ST_MIN:   cfg_q.st_min   <= pwdata[7:0];
				REG_TIMEOUT:  cfg_q.timeout  <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_RX_MASK:  prdata = DATA_W'(cfg_q.rx_mask);
			REG_TX_ID:    prdata = DATA_W'(cfg_q.tx_id);
			REG_CAPACITY: prdata = DATA_W'(cfg_q.capacity);
			REG_BLK_SIZE: prdata = DATA_W'(cfg_q.blk_size);
			REG_ST_MIN:   prdata = DATA_W'(cfg_q.st_min);
			REG_TIMEOUT:  prdata = DATA_W'(cfg_q.timeout);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/isotp_rx_ctrl.sv -----
`default_nettype none

module isotp_rx_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	input  isotp_rx_pkg::dp_stat_t   stat,
	output isotp_rx_pkg::ctrl_cmd_t  cmd
);
	import isotp_rx_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   load;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_EMIT) && stat.work && slot_free;

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_ready && in_valid;
		cmd.decode    = (state_q == S_DECODE);
		cmd.load_byte = load && stat.bytes_left;
		cmd.load_tail = load && !stat.bytes_left;
		cmd.last      = stat.closing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!stat.work || (load && stat.closing))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/isotp_rx_dpath.sv -----
`default_nettype none

module isotp_rx_dpath (
	input  wire                      clk,
	input  wire                      arst_n,
	input  isotp_rx_pkg::cfg_t       cfg,
	input  isotp_rx_pkg::req_t       req,
	input  isotp_rx_pkg::ctrl_cmd_t  cmd,
	output isotp_rx_pkg::dp_stat_t   stat,
	output isotp_rx_pkg::res_t       res
);
	import isotp_rx_pkg::*;

	// captured frame
	logic            tick_q;
	logic [ID_W-1:0] id_q;
	logic [7:0]      data_q [8];

	// protocol state
	logic             rcv_q;
	logic [3:0]       seq_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] total_q;
	logic [LEN_W-1:0] off_q;
	logic [TMO_W-1:0] elapsed_q;

	// emission plan
	logic [2:0]       cnt_q;
	logic [2:0]       idx_q;
	logic             tail_q;
	logic [1:0]       tkind_q;
	logic [2:0]       tstat_q;
	logic [3:0]       tbs_q;
	logic [LEN_W-1:0] tlen_q;

	res_t res_q;
	res_t n_res;

	// decode results
	logic             n_rcv;
	logic [3:0]       n_seq;
	logic [LEN_W-1:0] n_rem;
	logic [LEN_W-1:0] n_total;
	logic [TMO_W-1:0] n_elapsed;
	logic             n_off_clr;
	logic [2:0]       n_cnt;
	logic [2:0]       n_idx;
	logic             n_tail;
	logic [1:0]       n_tkind;
	logic [2:0]       n_tstat;
	logic [3:0]       n_tbs;
	logic [LEN_W-1:0] n_tlen;

	logic [3:0]       pci_type;
	logic [3:0]       pci_lo;
	logic [LEN_W-1:0] limit;
	logic [LEN_W-1:0] ff_len;
	logic [2:0]       cf_n;
	logic [LEN_W-1:0] cf_rem;
	logic [3:0]       cf_seq;
	logic [LEN_W:0]   cf_rem6;
	logic             blk_end;
	logic [3:0]       want;

	assign pci_type = data_q[0][7:4];
	assign pci_lo   = data_q[0][3:0];
	assign limit    = (cfg.capacity < LEN_W'(MAX_MESSAGE_BYTES)) ?
	                  cfg.capacity : LEN_W'(MAX_MESSAGE_BYTES);
	assign ff_len   = {pci_lo, data_q[1]};
	assign cf_n     = (rem_q < LEN_W'(CF_DATA_BYTES)) ? rem_q[2:0] : 3'(CF_DATA_BYTES);
	assign cf_rem   = rem_q - {{(LEN_W-3){1'b0}}, cf_n};
	assign cf_seq   = seq_q + 4'd1;
	assign cf_rem6  = {1'b0, cf_rem} + (LEN_W+1)'(CF_DATA_BYTES - 1);

	// new sequence number lands on a multiple of the block size
	always_comb begin
		blk_end = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (({4'b0, 4'(k)} * {4'b0, cfg.blk_size}) == {4'b0, cf_seq})
				blk_end = 1'b1;
		end
		if (cfg.blk_size == 4'd0)
			blk_end = 1'b0;
	end

	// min(block size, ceil(remaining / 7)) without a divider
	always_comb begin
		want = 4'd0;
		for (int k = 1; k < 16; k++) begin
			if ((4'(k) <= cfg.blk_size) && ((LEN_W+1)'(CF_DATA_BYTES * k) <= cf_rem6))
				want = 4'(k);
		end
	end

	always_comb begin
		n_rcv     = rcv_q;
		n_seq     = seq_q;
		n_rem     = rem_q;
		n_total   = total_q;
		n_elapsed = elapsed_q;
		n_off_clr = 1'b0;
		n_cnt     = 3'd0;
		n_idx     = 3'd1;
		n_tail    = 1'b0;
		n_tkind   = KIND_ERR;
		n_tstat   = ST_OK;
		n_tbs     = 4'd0;
		n_tlen    = '0;

		if (tick_q) begin
			if (rcv_q) begin
				if (({1'b0, elapsed_q} + (TMO_W+1)'(1)) > {1'b0, cfg.timeout}) begin
					n_tail  = 1'b1;
					n_tstat = ST_TIMEOUT;
				end else begin
					n_elapsed = elapsed_q + TMO_W'(1);
				end
			end
		end else if (!rcv_q) begin
			if ((id_q & cfg.rx_mask) != cfg.rx_mask) begin
				n_tail  = 1'b1;
				n_tstat = ST_BAD_ID;
			end else if (pci_type == PCI_SF) begin
				if ((pci_lo == 4'd0) || (pci_lo > 4'(SF_MAX_LEN))) begin
					n_tail  = 1'b1;
					n_tstat = ST_BAD_LEN;
				end else if ({{(LEN_W-4){1'b0}}, pci_lo} > limit) begin
					n_tail  = 1'b1;
					n_tstat = ST_NO_SPACE;
				end else begin
					n_off_clr = 1'b1;
					n_cnt     = pci_lo[2:0];
					n_idx     = 3'd1;
					n_tail    = 1'b1;
					n_tkind   = KIND_DONE;
					n_tlen    = {{(LEN_W-4){1'b0}}, pci_lo};
				end
			end else if (pci_type == PCI_FF) begin
				if ((ff_len < LEN_W'(FF_MIN_LEN)) || (ff_len > limit)) begin
					n_tail  = 1'b1;
					n_tstat = ST_BAD_LEN;
				end else begin
					n_off_clr = 1'b1;
					n_cnt     = 3'(FF_DATA_BYTES);
					n_idx     = 3'd2;
					n_tail    = 1'b1;
					n_tkind   = KIND_FC;
					n_tbs     = cfg.blk_size;
					n_rcv     = 1'b1;
					n_seq     = 4'd1;
					n_total   = ff_len;
					n_rem     = ff_len - LEN_W'(FF_DATA_BYTES);
					n_elapsed = '0;
				end
			end else begin
				n_tail  = 1'b1;
				n_tstat = ST_BAD_TYPE;
			end
		end else begin
			if (pci_type != PCI_CF) begin
				n_tail  = 1'b1;
				n_tstat = ST_BAD_TYPE;
			end else if (pci_lo != seq_q) begin
				n_tail  = 1'b1;
				n_tstat = ST_SEQUENCE;
			end else begin
				n_cnt = cf_n;
				n_idx = 3'd1;
				n_rem = cf_rem;
				n_seq = cf_seq;
				if (cf_rem == '0) begin
					n_tail  = 1'b1;
					n_tkind = KIND_DONE;
					n_tlen  = total_q;
				end else if (blk_end) begin
					n_tail  = 1'b1;
					n_tkind = KIND_FC;
					n_tbs   = want;
				end
			end
		end

		// done and error both drop back to idle
		if (n_tail && (n_tkind != KIND_FC)) begin
			n_rcv     = 1'b0;
			n_seq     = 4'd0;
			n_rem     = '0;
			n_total   = '0;
			n_elapsed = '0;
		end
	end

	// next result: a payload byte, or the closing flow control / done / error
	always_comb begin
		n_res = '0;
		if (cmd.load_byte) begin
			n_res.kind         = KIND_BYTE;
			n_res.payload_byte = data_q[idx_q];
			n_res.byte_offset  = off_q;
			n_res.last         = cmd.last;
		end else begin
			n_res.kind           = tkind_q;
			n_res.fc_id          = (tkind_q == KIND_FC) ? cfg.tx_id : '0;
			n_res.fc_block_size  = tbs_q;
			n_res.fc_separation  = (tkind_q == KIND_FC) ? cfg.st_min : 8'd0;
			n_res.status         = tstat_q;
			n_res.message_length = tlen_q;
			n_res.last           = 1'b1;
		end
	end

	assign stat.work       = (cnt_q != 3'd0) || tail_q;
	assign stat.bytes_left = (cnt_q != 3'd0);
	assign stat.closing    = ((cnt_q == 3'd1) && !tail_q) || ((cnt_q == 3'd0) && tail_q);
	assign res             = res_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tick_q    <= req.req_type;
			id_q      <= req.frame_id;
			data_q[0] <= req.byte0;
			data_q[1] <= req.byte1;
			data_q[2] <= req.byte2;
			data_q[3] <= req.byte3;
			data_q[4] <= req.byte4;
			data_q[5] <= req.byte5;
			data_q[6] <= req.byte6;
			data_q[7] <= req.byte7;
		end
		if (cmd.decode) begin
			idx_q   <= n_idx;
			tkind_q <= n_tkind;
			tstat_q <= n_tstat;
			tbs_q   <= n_tbs;
			tlen_q  <= n_tlen;
		end else if (cmd.load_byte) begin
			idx_q <= idx_q + 3'd1;
		end
		if (cmd.load_byte || cmd.load_tail)
			res_q <= n_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q     <= 1'b0;
			seq_q     <= 4'd0;
			rem_q     <= '0;
			total_q   <= '0;
			off_q     <= '0;
			elapsed_q <= '0;
			cnt_q     <= 3'd0;
			tail_q    <= 1'b0;
		end else begin
			if (cmd.decode) begin
				rcv_q     <= n_rcv;
				seq_q     <= n_seq;
				rem_q     <= n_rem;
				total_q   <= n_total;
				elapsed_q <= n_elapsed;
				cnt_q     <= n_cnt;
				tail_q    <= n_tail;
				if (n_off_clr)
					off_q <= '0;
			end else begin
				if (cmd.load_byte) begin
					cnt_q <= cnt_q - 3'd1;
					off_q <= off_q + LEN_W'(1);
				end
				if (cmd.load_tail)
					tail_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/isotp_rx_reassembler.sv -----
// Channel  | Dir | Handshake      | Beat
// ---------+-----+----------------+-------------------------------------------
// req      | in  | valid / ready  | one CAN frame or one millisecond tick
// res      | out | valid / ready  | one result: byte, flow control, done, error
// apb      | in  | psel / penable | register write or read, pready tied high
//
// An input beat is accepted, then decoded, then emits its results one per
// free output slot; a beat with no result still passes through the emit state.
// The single output register paces the result stream.
// arst_n clears control state and loads register reset values; frame and
// result payload registers carry no reset. A stalled res channel holds the
// controller in its emit state; req.ready is high only while idle, and the
// next frame may be taken while the last result still sits in the output.
`default_nettype none

module isotp_rx_reassembler (
	input  wire                                clk,
	input  wire                                arst_n,
	isotp_rx_in_if.sink                        req,
	isotp_rx_out_if.source                     res,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [isotp_rx_pkg::ADDR_W-1:0]    paddr,
	input  wire  [isotp_rx_pkg::DATA_W-1:0]    pwdata,
	output logic [isotp_rx_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);
	import isotp_rx_pkg::*;

	cfg_t      cfg;
	req_t      req_pl;
	res_t      res_pl;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign pready = 1'b1;

	// flatten the request beat for the datapath capture registers
	assign req_pl.req_type = req.req_type;
	assign req_pl.frame_id = req.frame_id;
	assign req_pl.byte0    = req.byte0;
	assign req_pl.byte1    = req.byte1;
	assign req_pl.byte2    = req.byte2;
	assign req_pl.byte3    = req.byte3;
	assign req_pl.byte4    = req.byte4;
	assign req_pl.byte5    = req.byte5;
	assign req_pl.byte6    = req.byte6;
	assign req_pl.byte7    = req.byte7;

	// result register fans straight out to the res channel
	assign res.kind           = res_pl.kind;
	assign res.payload_byte   = res_pl.payload_byte;
	assign res.byte_offset    = res_pl.byte_offset;
	assign res.fc_id          = res_pl.fc_id;
	assign res.fc_block_size  = res_pl.fc_block_size;
	assign res.fc_separation  = res_pl.fc_separation;
	assign res.status         = res_pl.status;
	assign res.message_length = res_pl.message_length;
	assign res.last           = res_pl.last;

	// register bank: receive mask, transmit id, capacity, block size,
	// STmin, timeout at byte addresses 0x00..0x14
	isotp_rx_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: idle -> decode -> emit one result per free output slot
	isotp_rx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// frame capture, protocol state, emission plan and output register
	isotp_rx_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req_pl),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res_pl)
	);

endmodule

`default_nettype wire
